/* sv/mwalu_pkg.sv */
// shared types and constants for the mixed-width integer alu
package mwalu_pkg;

    localparam int DATA_W        = 64;
    localparam int WID_W         = 7;
    localparam int FUNC_W        = 5;
    localparam int DEF_MAX_WIDTH = 64;

    typedef enum logic [FUNC_W-1:0] {
        F_ADD      = 5'd0,
        F_SUB      = 5'd1,
        F_INC      = 5'd2,
        F_DEC      = 5'd3,
        F_CONV     = 5'd4,
        F_NOT      = 5'd5,
        F_AND      = 5'd6,
        F_OR       = 5'd7,
        F_XOR      = 5'd8,
        F_NAND     = 5'd9,
        F_NOR      = 5'd10,
        F_XNOR     = 5'd11,
        F_NEQ      = 5'd12,
        F_EQ       = 5'd13,
        F_LESS     = 5'd14,
        F_GREATER  = 5'd15,
        F_NLESS    = 5'd16,
        F_NGREATER = 5'd17,
        F_SHL      = 5'd18,
        F_SHR      = 5'd19,
        F_CMP      = 5'd20
    } t_func;

    typedef struct packed {
        logic              valid;
        logic [FUNC_W-1:0] func;
    } t_ctl;

endpackage

/* sv/mwalu_extend.sv */
// first stage: width clamping, operand extension and mask generation
module mwalu_extend #(
    parameter int MAX_WIDTH = mwalu_pkg::DEF_MAX_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  mwalu_pkg::t_ctl              i_ctl,
    input  logic [MAX_WIDTH-1:0]         i_a_value,
    input  logic [mwalu_pkg::WID_W-1:0]  i_a_width,
    input  logic                         i_a_signed,
    input  logic [MAX_WIDTH-1:0]         i_b_value,
    input  logic [mwalu_pkg::WID_W-1:0]  i_b_width,
    input  logic                         i_b_signed,
    input  logic [mwalu_pkg::WID_W-1:0]  i_shift_amount,
    input  logic [mwalu_pkg::WID_W-1:0]  i_result_width,
    output mwalu_pkg::t_ctl              o_ctl,
    output logic [MAX_WIDTH-1:0]         o_a_ext,
    output logic [MAX_WIDTH-1:0]         o_b_ext,
    output logic [MAX_WIDTH-1:0]         o_shl_src,
    output logic                         o_shr_fill,
    output logic [mwalu_pkg::WID_W-1:0]  o_shift,
    output logic [MAX_WIDTH-1:0]         o_cmp_mask,
    output logic [MAX_WIDTH-1:0]         o_res_mask
);

    localparam int W     = MAX_WIDTH;
    localparam int WW    = mwalu_pkg::WID_W;
    localparam int IDX_W = $clog2(W);
    localparam logic [WW-1:0] W_CODE = WW'(W);

    function automatic logic [W-1:0] low_mask(input logic [WW-1:0] n);
        low_mask = ~({W{1'b1}} << n);
    endfunction

    logic [WW-1:0] na, nb, nr, ntop;
    logic [WW-1:0] na_m1, nb_m1;
    logic [WW:0]   shl_idx;
    logic [W-1:0]  ma, mb;
    logic [W-1:0]  a_low, b_low;
    logic          a_top, b_top, a_fill, b_fill, shl_fill;
    logic [W-1:0]  a_ext, b_ext, shl_src;
    logic          inc_dec;

    logic                             r_valid;
    logic [mwalu_pkg::FUNC_W-1:0]     r_func;
    logic [W-1:0]                     r_a_ext, r_b_ext, r_shl_src, r_cmp_mask, r_res_mask;
    logic                             r_shr_fill;
    logic [WW-1:0]                    r_shift;

    assign na   = (i_a_width > W_CODE) ? W_CODE : i_a_width;
    assign nb   = (i_b_width > W_CODE) ? W_CODE : i_b_width;
    assign nr   = (i_result_width > W_CODE) ? W_CODE : i_result_width;
    assign ntop = (na > nb) ? na : nb;

    assign ma    = low_mask(na);
    assign mb    = low_mask(nb);
    assign a_low = i_a_value & ma;
    assign b_low = i_b_value & mb;

    assign na_m1 = na - WW'(1);
    assign nb_m1 = nb - WW'(1);
    assign a_top = (na != '0) && a_low[na_m1[IDX_W-1:0]];
    assign b_top = (nb != '0) && b_low[nb_m1[IDX_W-1:0]];

    assign a_fill = i_a_signed & a_top;
    assign b_fill = i_b_signed & b_top;
    assign a_ext  = a_low | ({W{a_fill}} & ~ma);

    // inc and dec use a constant one as second operand
    assign inc_dec = (i_ctl.func == mwalu_pkg::F_INC) || (i_ctl.func == mwalu_pkg::F_DEC);
    assign b_ext   = inc_dec ? W'(1) : (b_low | ({W{b_fill}} & ~mb));

    // left shift fill comes from a bit below the top, zero when out of range
    assign shl_idx  = {1'b0, na} - {1'b0, i_shift_amount} - (WW+1)'(1);
    assign shl_fill = !shl_idx[WW] && i_a_signed && a_low[shl_idx[IDX_W-1:0]];
    assign shl_src  = a_low | ({W{shl_fill}} & ~ma);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_func     <= i_ctl.func;
            r_a_ext    <= a_ext;
            r_b_ext    <= b_ext;
            r_shl_src  <= shl_src;
            r_shr_fill <= a_fill;
            r_shift    <= i_shift_amount;
            r_cmp_mask <= low_mask(ntop);
            r_res_mask <= low_mask(nr);
        end
    end

    assign o_ctl      = '{valid: r_valid, func: r_func};
    assign o_a_ext    = r_a_ext;
    assign o_b_ext    = r_b_ext;
    assign o_shl_src  = r_shl_src;
    assign o_shr_fill = r_shr_fill;
    assign o_shift    = r_shift;
    assign o_cmp_mask = r_cmp_mask;
    assign o_res_mask = r_res_mask;

endmodule

/* sv/mwalu_exec.sv */
// second stage: adder, shifter, bitwise logic and magnitude compare
module mwalu_exec #(
    parameter int MAX_WIDTH = mwalu_pkg::DEF_MAX_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  mwalu_pkg::t_ctl              i_ctl,
    input  logic [MAX_WIDTH-1:0]         i_a_ext,
    input  logic [MAX_WIDTH-1:0]         i_b_ext,
    input  logic [MAX_WIDTH-1:0]         i_shl_src,
    input  logic                         i_shr_fill,
    input  logic [mwalu_pkg::WID_W-1:0]  i_shift,
    input  logic [MAX_WIDTH-1:0]         i_cmp_mask,
    input  logic [MAX_WIDTH-1:0]         i_res_mask,
    output mwalu_pkg::t_ctl              o_ctl,
    output logic [MAX_WIDTH-1:0]         o_arith,
    output logic [MAX_WIDTH-1:0]         o_shifted,
    output logic [MAX_WIDTH-1:0]         o_logic,
    output logic                         o_lt,
    output logic                         o_eq,
    output logic [MAX_WIDTH-1:0]         o_res_mask
);

    localparam int W = MAX_WIDTH;

    logic [W-1:0]        arith, shifted, logic_v, shr_v, am, bm;
    logic signed [W:0]   shr_wide;
    logic                add_op;

    logic                             r_valid;
    logic [mwalu_pkg::FUNC_W-1:0]     r_func;
    logic [W-1:0]                     r_arith, r_shifted, r_logic, r_res_mask;
    logic                             r_lt, r_eq;

    assign add_op = (i_ctl.func == mwalu_pkg::F_ADD) || (i_ctl.func == mwalu_pkg::F_INC);
    assign arith  = add_op ? (i_a_ext + i_b_ext) : (i_a_ext - i_b_ext);

    assign shr_wide = $signed({i_shr_fill, i_a_ext}) >>> i_shift;
    assign shr_v    = shr_wide[W-1:0];
    assign shifted  = (i_ctl.func == mwalu_pkg::F_SHL) ? (i_shl_src << i_shift) : shr_v;

    always_comb begin
        unique case (i_ctl.func)
            mwalu_pkg::F_NOT:  logic_v = ~i_a_ext;
            mwalu_pkg::F_AND:  logic_v = i_a_ext & i_b_ext;
            mwalu_pkg::F_OR:   logic_v = i_a_ext | i_b_ext;
            mwalu_pkg::F_XOR:  logic_v = i_a_ext ^ i_b_ext;
            mwalu_pkg::F_NAND: logic_v = ~(i_a_ext & i_b_ext);
            mwalu_pkg::F_NOR:  logic_v = ~(i_a_ext | i_b_ext);
            mwalu_pkg::F_XNOR: logic_v = ~(i_a_ext ^ i_b_ext);
            default:           logic_v = i_a_ext;
        endcase
    end

    // highest differing bit decides, same as unsigned compare over the span
    assign am = i_a_ext & i_cmp_mask;
    assign bm = i_b_ext & i_cmp_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_func     <= i_ctl.func;
            r_arith    <= arith;
            r_shifted  <= shifted;
            r_logic    <= logic_v;
            r_lt       <= (am < bm);
            r_eq       <= (am == bm);
            r_res_mask <= i_res_mask;
        end
    end

    assign o_ctl      = '{valid: r_valid, func: r_func};
    assign o_arith    = r_arith;
    assign o_shifted  = r_shifted;
    assign o_logic    = r_logic;
    assign o_lt       = r_lt;
    assign o_eq       = r_eq;
    assign o_res_mask = r_res_mask;

endmodule

/* sv/mixed_width_integer_alu_unit.sv */
// top level of the mixed-width integer alu: three-stage pipeline with output select
//
//  channel   dir   handshake            payload
//  request   in    i_valid / o_stall    i_func, i_a_*, i_b_*, i_shift_amount, i_result_width
//  result    out   o_valid / i_stall    o_result
//
//  one request per cycle sustained while the output is not stalled
//  results pass through the extend, execute and select register stages
//  synchronous active-low reset clears the stage valid bits only
//  a stalled stage holds, empty stages ahead of it keep filling
//  o_stall is high only with all three stages full and i_stall high
module mixed_width_integer_alu_unit #(
    parameter int MAX_WIDTH = mwalu_pkg::DEF_MAX_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [mwalu_pkg::FUNC_W-1:0]  i_func,
    input  logic [mwalu_pkg::DATA_W-1:0]  i_a_value,
    input  logic [mwalu_pkg::WID_W-1:0]   i_a_width,
    input  logic                          i_a_signed,
    input  logic [mwalu_pkg::DATA_W-1:0]  i_b_value,
    input  logic [mwalu_pkg::WID_W-1:0]   i_b_width,
    input  logic                          i_b_signed,
    input  logic [mwalu_pkg::WID_W-1:0]   i_shift_amount,
    input  logic [mwalu_pkg::WID_W-1:0]   i_result_width,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [mwalu_pkg::DATA_W-1:0]  o_result
);

    localparam int W = MAX_WIDTH;

    mwalu_pkg::t_ctl               in_ctl, ctl1, ctl2;
    logic                          en1, en2, en3;
    logic [W-1:0]                  a_ext, b_ext, shl_src, cmp_mask, res_mask1;
    logic                          shr_fill;
    logic [mwalu_pkg::WID_W-1:0]   shift;
    logic [W-1:0]                  arith, shifted, logic_v, res_mask2;
    logic                          lt, eq;
    logic [W-1:0]                  sel;
    logic [W-1:0]                  n_result;

    logic                          r_valid;
    logic [mwalu_pkg::FUNC_W-1:0]  r_func;
    logic [W-1:0]                  r_result;

    assign en3     = !r_valid || !i_stall;
    assign en2     = !ctl2.valid || en3;
    assign en1     = !ctl1.valid || en2;
    assign o_stall = !en1;

    assign in_ctl = '{valid: i_valid, func: i_func};

    mwalu_extend #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_extend (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en1),
        .i_ctl          (in_ctl),
        .i_a_value      (i_a_value[W-1:0]),
        .i_a_width      (i_a_width),
        .i_a_signed     (i_a_signed),
        .i_b_value      (i_b_value[W-1:0]),
        .i_b_width      (i_b_width),
        .i_b_signed     (i_b_signed),
        .i_shift_amount (i_shift_amount),
        .i_result_width (i_result_width),
        .o_ctl          (ctl1),
        .o_a_ext        (a_ext),
        .o_b_ext        (b_ext),
        .o_shl_src      (shl_src),
        .o_shr_fill     (shr_fill),
        .o_shift        (shift),
        .o_cmp_mask     (cmp_mask),
        .o_res_mask     (res_mask1)
    );

    mwalu_exec #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_exec (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en2),
        .i_ctl      (ctl1),
        .i_a_ext    (a_ext),
        .i_b_ext    (b_ext),
        .i_shl_src  (shl_src),
        .i_shr_fill (shr_fill),
        .i_shift    (shift),
        .i_cmp_mask (cmp_mask),
        .i_res_mask (res_mask1),
        .o_ctl      (ctl2),
        .o_arith    (arith),
        .o_shifted  (shifted),
        .o_logic    (logic_v),
        .o_lt       (lt),
        .o_eq       (eq),
        .o_res_mask (res_mask2)
    );

    always_comb begin
        unique case (ctl2.func)
            mwalu_pkg::F_ADD,
            mwalu_pkg::F_SUB,
            mwalu_pkg::F_INC,
            mwalu_pkg::F_DEC:      sel = arith;
            mwalu_pkg::F_CONV,
            mwalu_pkg::F_NOT,
            mwalu_pkg::F_AND,
            mwalu_pkg::F_OR,
            mwalu_pkg::F_XOR,
            mwalu_pkg::F_NAND,
            mwalu_pkg::F_NOR,
            mwalu_pkg::F_XNOR:     sel = logic_v;
            mwalu_pkg::F_SHL,
            mwalu_pkg::F_SHR:      sel = shifted;
            mwalu_pkg::F_NEQ:      sel = W'(!eq);
            mwalu_pkg::F_EQ:       sel = W'(eq);
            mwalu_pkg::F_LESS:     sel = W'(lt);
            mwalu_pkg::F_GREATER:  sel = W'(!eq && !lt);
            mwalu_pkg::F_NLESS:    sel = W'(!lt);
            mwalu_pkg::F_NGREATER: sel = W'(eq || lt);
            mwalu_pkg::F_CMP:      sel = eq ? '0 : {{(W-1){lt}}, 1'b1};
            default:               sel = '0;
        endcase
    end

    assign n_result = sel & res_mask2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en3) begin
            r_valid <= ctl2.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_func   <= ctl2.func;
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = mwalu_pkg::DATA_W'(r_result);

    // an accepted request always lands in the first stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> ctl1.valid)
        else $error("accepted request not captured in first stage");

    // input stall only when every stage is full and the output is blocked
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> ctl1.valid && ctl2.valid && r_valid && i_stall)
        else $error("input stalled with room in the pipeline");

    // a valid second stage moving forward reaches the output register
    a_stage_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl2.valid && en3 |=> r_valid)
        else $error("second stage request lost");

    // boolean compare results carry only bit zero; F_CMP is outside this check
    a_cmp_bit0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && (r_func == mwalu_pkg::F_NEQ || r_func == mwalu_pkg::F_EQ ||
                    r_func == mwalu_pkg::F_LESS || r_func == mwalu_pkg::F_GREATER ||
                    r_func == mwalu_pkg::F_NLESS || r_func == mwalu_pkg::F_NGREATER)
        |-> (o_result >> 1) == '0)
        else $error("compare result has upper bits set");

endmodule
